FILE: rtl/core/csma_pkg.sv
package csma_pkg;

  localparam int COORD_W        = 12;
  localparam int SUM_W          = 56;
  localparam int IDX_W          = 5;
  localparam int NUM_MOMENTS    = 14;
  localparam int MOM_IDX_W      = 4;
  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [IDX_W-1:0] FIRST_INDEX = IDX_W'(0);
  localparam logic [IDX_W-1:0] COUNT_INDEX = IDX_W'(20);

  // moment slots
  localparam logic [MOM_IDX_W-1:0] M_X4   = 4'd0;
  localparam logic [MOM_IDX_W-1:0] M_X3Y  = 4'd1;
  localparam logic [MOM_IDX_W-1:0] M_X2Y2 = 4'd2;
  localparam logic [MOM_IDX_W-1:0] M_X3   = 4'd3;
  localparam logic [MOM_IDX_W-1:0] M_X2Y  = 4'd4;
  localparam logic [MOM_IDX_W-1:0] M_X2   = 4'd5;
  localparam logic [MOM_IDX_W-1:0] M_XY3  = 4'd6;
  localparam logic [MOM_IDX_W-1:0] M_XY2  = 4'd7;
  localparam logic [MOM_IDX_W-1:0] M_XY   = 4'd8;
  localparam logic [MOM_IDX_W-1:0] M_Y4   = 4'd9;
  localparam logic [MOM_IDX_W-1:0] M_Y3   = 4'd10;
  localparam logic [MOM_IDX_W-1:0] M_Y2   = 4'd11;
  localparam logic [MOM_IDX_W-1:0] M_X    = 4'd12;
  localparam logic [MOM_IDX_W-1:0] M_Y    = 4'd13;

  typedef struct packed {
    logic             take;
    logic             load;
    logic             clear;
    logic [IDX_W-1:0] idx;
  } csma_cmd_t;

  typedef struct packed {
    logic final_taken;
    logic pipe_busy;
    logic out_free;
  } csma_sts_t;

  // moment slot behind each layout word; duplicates point at their twin
  function automatic logic [MOM_IDX_W-1:0] layout_src(input logic [IDX_W-1:0] idx);
    logic [MOM_IDX_W-1:0] m;
    unique case (idx)
      5'd0:  m = M_X4;
      5'd1:  m = M_X3Y;
      5'd2:  m = M_X2Y2;
      5'd3:  m = M_X3;
      5'd4:  m = M_X2Y;
      5'd5:  m = M_X2;
      5'd6:  m = M_X2Y2;
      5'd7:  m = M_XY3;
      5'd8:  m = M_X2Y;
      5'd9:  m = M_XY2;
      5'd10: m = M_XY;
      5'd11: m = M_Y4;
      5'd12: m = M_XY2;
      5'd13: m = M_Y3;
      5'd14: m = M_Y2;
      5'd15: m = M_X2;
      5'd16: m = M_XY;
      5'd17: m = M_X;
      5'd18: m = M_Y2;
      5'd19: m = M_Y;
      default: m = M_X4;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/csma_point_if.sv
interface csma_point_if
  import csma_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

FILE: rtl/core/csma_entry_if.sv
interface csma_entry_if
  import csma_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        entry_index;
  logic signed [SUM_W-1:0] entry_value;
  logic                    last_entry;

  modport source (output valid, entry_index, entry_value, last_entry, input ready);
  modport sink   (input valid, entry_index, entry_value, last_entry, output ready);
endinterface

FILE: rtl/core/csma_ctrl.sv
module csma_ctrl
  import csma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  csma_sts_t sts,
  output csma_cmd_t cmd
);

  typedef enum logic [1:0] {ACCUM, DRAIN, EMIT} state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;

  always_comb begin
    cmd.take  = (state == ACCUM);
    cmd.load  = (state == EMIT) && sts.out_free;
    cmd.clear = cmd.load && (idx == COUNT_INDEX);
    cmd.idx   = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ACCUM;
      idx   <= FIRST_INDEX;
    end else begin
      unique case (state)
        ACCUM: begin
          if (sts.final_taken) state <= DRAIN;
        end
        DRAIN: begin
          // wait until the last products have reached the sums
          if (!sts.pipe_busy) begin
            state <= EMIT;
            idx   <= FIRST_INDEX;
          end
        end
        EMIT: begin
          if (cmd.load) begin
            if (idx == COUNT_INDEX) begin
              state <= ACCUM;
              idx   <= FIRST_INDEX;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: state <= ACCUM;
      endcase
    end
  end

endmodule

FILE: rtl/core/csma_datapath.sv
module csma_datapath
  import csma_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  csma_point_if.sink          point,
  csma_entry_if.source        entry,
  input  csma_cmd_t           cmd,
  output csma_sts_t           sts
);

  localparam int CB    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  logic              accept;
  logic              take_pt;
  logic signed [CB-1:0] xs, ys;
  logic [CNT_W-1:0]  count;

  // stage 1
  logic                   v1;
  logic signed [CB-1:0]   x1, y1;
  logic signed [2*CB-1:0] x2_1, y2_1, xy_1;
  // stage 2
  logic                   v2;
  logic signed [CB-1:0]   x_2, y_2;
  logic signed [2*CB-1:0] x2_2, y2_2, xy_2;
  logic signed [3*CB-1:0] x3_2, x2y_2, xy2_2, y3_2;
  logic signed [4*CB-1:0] x4_2, x2y2_2, y4_2;
  // stage 3
  logic                   v3;
  logic signed [CB-1:0]   x_3, y_3;
  logic signed [2*CB-1:0] x2_3, y2_3, xy_3;
  logic signed [3*CB-1:0] x3_3, x2y_3, xy2_3, y3_3;
  logic signed [4*CB-1:0] x4_3, x2y2_3, y4_3, x3y_3, xy3_3;

  logic signed [SUM_W-1:0] mom  [NUM_MOMENTS];
  logic signed [SUM_W-1:0] sums [NUM_MOMENTS];
  logic signed [SUM_W-1:0] sel_value;

  assign point.ready = cmd.take;
  assign accept      = point.valid && point.ready;
  assign take_pt     = accept && (count < MAX_CNT);
  assign xs          = point.point_x[CB-1:0];
  assign ys          = point.point_y[CB-1:0];

  assign sts.final_taken = accept && point.final_point;
  assign sts.pipe_busy   = v1 || v2 || v3;
  assign sts.out_free    = !entry.valid || entry.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take_pt;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x1   <= xs;
    y1   <= ys;
    x2_1 <= xs * xs;
    y2_1 <= ys * ys;
    xy_1 <= xs * ys;

    x_2    <= x1;
    y_2    <= y1;
    x2_2   <= x2_1;
    y2_2   <= y2_1;
    xy_2   <= xy_1;
    x3_2   <= x2_1 * x1;
    x2y_2  <= x2_1 * y1;
    xy2_2  <= y2_1 * x1;
    y3_2   <= y2_1 * y1;
    x4_2   <= x2_1 * x2_1;
    x2y2_2 <= x2_1 * y2_1;
    y4_2   <= y2_1 * y2_1;

    x_3    <= x_2;
    y_3    <= y_2;
    x2_3   <= x2_2;
    y2_3   <= y2_2;
    xy_3   <= xy_2;
    x3_3   <= x3_2;
    x2y_3  <= x2y_2;
    xy2_3  <= xy2_2;
    y3_3   <= y3_2;
    x4_3   <= x4_2;
    x2y2_3 <= x2y2_2;
    y4_3   <= y4_2;
    x3y_3  <= x3_2 * y_2;
    xy3_3  <= y3_2 * x_2;
  end

  always_comb begin
    mom[M_X4]   = SUM_W'(x4_3);
    mom[M_X3Y]  = SUM_W'(x3y_3);
    mom[M_X2Y2] = SUM_W'(x2y2_3);
    mom[M_X3]   = SUM_W'(x3_3);
    mom[M_X2Y]  = SUM_W'(x2y_3);
    mom[M_X2]   = SUM_W'(x2_3);
    mom[M_XY3]  = SUM_W'(xy3_3);
    mom[M_XY2]  = SUM_W'(xy2_3);
    mom[M_XY]   = SUM_W'(xy_3);
    mom[M_Y4]   = SUM_W'(y4_3);
    mom[M_Y3]   = SUM_W'(y3_3);
    mom[M_Y2]   = SUM_W'(y2_3);
    mom[M_X]    = SUM_W'(x_3);
    mom[M_Y]    = SUM_W'(y_3);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      for (int i = 0; i < NUM_MOMENTS; i++) sums[i] <= '0;
    end else begin
      if (take_pt) count <= count + CNT_W'(1);
      if (v3) begin
        for (int i = 0; i < NUM_MOMENTS; i++) sums[i] <= sums[i] + mom[i];
      end
    end
  end

  always_comb begin
    if (cmd.idx == COUNT_INDEX) sel_value = SUM_W'(count);
    else                        sel_value = sums[layout_src(cmd.idx)];
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (cmd.load) begin
      entry.valid <= 1'b1;
    end else if (entry.ready) begin
      entry.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry.entry_index <= cmd.idx;
      entry.entry_value <= sel_value;
      entry.last_entry  <= (cmd.idx == COUNT_INDEX);
    end
  end

endmodule

FILE: rtl/core/conic_scatter_matrix_accumulator_top.sv
// Scatter-matrix moment accumulator for conic fitting.
// Input channel "point": one signed (x, y) per word; final_point marks the
// last point of a set. Points are taken one per cycle while ready is high.
// Each point runs through a three-stage multiplier pipeline (squares, then
// cubes and fourth powers, then x^3*y and x*y^3) into fourteen 56-bit sums.
// Only the low COORD_BITS of each coordinate are used, sign-extended.
// After MAX_POINTS points further points are neither summed nor counted.
// Once the final point is taken, ready drops; after the pipeline drains
// the output channel "entry" carries 21 words, index 0 to 20, one per
// cycle when the receiver is ready: moment sums with duplicate slots
// copied, and the point count at index 20 with last_entry set.
// Loading word 20 clears all sums and the count, and ready rises again
// the next cycle, so a new set can be taken while word 20 still waits.
// A stalled receiver holds the current word and pauses emission.
// Reset (rst, synchronous) clears the sums, count, pipeline and output.
module conic_scatter_matrix_accumulator_top
  import csma_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input logic          clk,
  input logic          rst,
  csma_point_if.sink   point,
  csma_entry_if.source entry
);

  csma_cmd_t cmd;
  csma_sts_t sts;

  csma_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  csma_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .point (point),
    .entry (entry),
    .cmd   (cmd),
    .sts   (sts)
  );

endmodule

FILE: rtl/core/csma_checker.sv
module csma_checker
  import csma_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_final,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [IDX_W-1:0]        out_index,
  input logic signed [SUM_W-1:0] out_value,
  input logic                    out_last
);

  // a final point closes the input until the last word of its layout has been loaded
  a_final_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("input taken straight after a final point");

  a_last_is_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_index == COUNT_INDEX)
    else $error("last word not at count index");

  // words of one layout follow back to back in index order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=>
      out_valid && out_index == $past(out_index) + IDX_W'(1))
    else $error("layout word missing or out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_index) && $stable(out_value) && $stable(out_last))
    else $error("stalled word changed");

endmodule

bind conic_scatter_matrix_accumulator_top csma_checker u_csma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (point.valid),
  .in_ready  (point.ready),
  .in_final  (point.final_point),
  .out_valid (entry.valid),
  .out_ready (entry.ready),
  .out_index (entry.entry_index),
  .out_value (entry.entry_value),
  .out_last  (entry.last_entry)
);

FILE: test/tb_conic_scatter_matrix_accumulator_top.sv
`timescale 1ns / 100ps

module tb_conic_scatter_matrix_accumulator_top;
  import csma_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int POINT_CAP   = MAX_POINTS_DEF;
  localparam int SHOW_LIMIT  = 10;
  localparam int HOLD_LEN    = 400;
  localparam int RAND_ITEMS  = 375;
  localparam int EXTREME_SET = 40;

  // moment behind each of layout words 0..19
  localparam logic [MOM_IDX_W-1:0] WORD_SRC [20] = '{
    M_X4, M_X3Y, M_X2Y2, M_X3, M_X2Y, M_X2, M_X2Y2, M_XY3, M_X2Y, M_XY2,
    M_XY, M_Y4, M_XY2, M_Y3, M_Y2, M_X2, M_XY, M_X, M_Y2, M_Y
  };

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [SUM_W-1:0] value;
    logic                    last;
  } layout_word_t;

  class scatter_tracker;
    longint       sums [NUM_MOMENTS];
    int unsigned  n_points;
    layout_word_t pending_words [$];
    int unsigned  mismatches;

    function new();
      clear_sums();
      mismatches = 0;
    endfunction

    function void clear_sums();
      foreach (sums[i]) sums[i] = 0;
      n_points = 0;
    endfunction

    // low CB bits, sign-extended
    function longint coord(logic [COORD_W-1:0] raw);
      longint v;
      v = longint'(raw) & ((longint'(1) << CB) - 1);
      if (v[CB-1]) v = v - (longint'(1) << CB);
      return v;
    endfunction

    function void take_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic fin);
      longint       x, y, x2, y2, x3, y3;
      layout_word_t w;
      int           k;
      x = coord(px);
      y = coord(py);
      if (n_points < POINT_CAP) begin
        x2 = x * x;
        x3 = x2 * x;
        y2 = y * y;
        y3 = y2 * y;
        sums[M_X4]   += x2 * x2;
        sums[M_X3Y]  += x3 * y;
        sums[M_X2Y2] += x2 * y2;
        sums[M_X3]   += x3;
        sums[M_X2Y]  += x2 * y;
        sums[M_X2]   += x2;
        sums[M_XY3]  += y3 * x;
        sums[M_XY2]  += y2 * x;
        sums[M_XY]   += x * y;
        sums[M_Y4]   += y2 * y2;
        sums[M_Y3]   += y3;
        sums[M_Y2]   += y2;
        sums[M_X]    += x;
        sums[M_Y]    += y;
        n_points++;
      end
      if (fin) begin
        for (k = 0; k <= COUNT_INDEX; k++) begin
          w.index = IDX_W'(k);
          w.last  = (k == COUNT_INDEX);
          if (k == COUNT_INDEX) w.value = SUM_W'(n_points);
          else w.value = SUM_W'(sums[WORD_SRC[k]]);
          pending_words.push_back(w);
        end
        clear_sums();
      end
    endfunction

    function void check_word(logic [IDX_W-1:0] idx, logic signed [SUM_W-1:0] val,
                             logic last);
      layout_word_t e;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected word: index %0d value %0d last %0b", idx, val, last);
        return;
      end
      e = pending_words.pop_front();
      if (e.index !== idx || e.value !== val || e.last !== last) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("word mismatch: index %0d/%0d value %0d/%0d last %0b/%0b (exp/got)",
                   e.index, idx, e.value, val, e.last, last);
      end
    endfunction

    function int unsigned waiting();
      return pending_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  csma_point_if point_ch ();
  csma_entry_if entry_ch ();

  conic_scatter_matrix_accumulator_top dut (
    .clk   (clk),
    .rst   (rst),
    .point (point_ch),
    .entry (entry_ch)
  );

  always #5 clk = ~clk;

  scatter_tracker sb;
  bit sender_calm = 1'b0;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;
  int calm_left   = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 4))
        0: return -COORD_W'(2048);
        1: return COORD_W'(2047);
        2: return '0;
        3: return '1;
        default: return COORD_W'(1);
      endcase
    end
    return COORD_W'($urandom);
  endfunction

  // receiver: random stalls, calm stretches, and one long hold-off on request
  always @(posedge clk) begin
    if (!rst && entry_ch.valid && entry_ch.ready)
      sb.check_word(entry_ch.entry_index, entry_ch.entry_value, entry_ch.last_entry);
    if (hold_left > 0) begin
      entry_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN - 1;
      entry_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      entry_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      entry_ch.ready <= 1'b1;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      else if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 80);
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic fin);
    int gap;
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) begin
        // junk on the bus while idle
        point_ch.point_x     <= COORD_W'($urandom);
        point_ch.point_y     <= COORD_W'($urandom);
        point_ch.final_point <= 1'($urandom);
        @(posedge clk);
      end
    end
    point_ch.valid       <= 1'b1;
    point_ch.point_x     <= px;
    point_ch.point_y     <= py;
    point_ch.final_point <= fin;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    sb.take_point(px, py, fin);
  endtask

  task automatic send_set(input int n);
    int i;
    for (i = 1; i <= n; i++) send_point(rand_coord(), rand_coord(), i == n);
  endtask

  initial begin
    int sent;
    int n;
    int sets;
    int i;
    sb = new();
    point_ch.valid       = 1'b0;
    point_ch.point_x     = '0;
    point_ch.point_y     = '0;
    point_ch.final_point = 1'b0;
    entry_ch.ready       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-point sets
    send_point(COORD_W'(5), -COORD_W'(3), 1'b1);
    send_point(-COORD_W'(2048), -COORD_W'(2048), 1'b1);
    send_point(COORD_W'(2047), COORD_W'(2047), 1'b1);
    send_point('0, '0, 1'b1);
    // corners of the coordinate range
    send_point(-COORD_W'(2048), -COORD_W'(2048), 1'b0);
    send_point(COORD_W'(2047), COORD_W'(2047), 1'b0);
    send_point(-COORD_W'(2048), COORD_W'(2047), 1'b0);
    send_point(COORD_W'(2047), -COORD_W'(2048), 1'b0);
    send_point('0, '0, 1'b0);
    send_point('1, COORD_W'(1), 1'b0);
    send_point(COORD_W'(1), '1, 1'b1);
    // one axis only
    send_point(COORD_W'(1000), '0, 1'b0);
    send_point(-COORD_W'(777), '0, 1'b1);
    send_point('0, COORD_W'(1234), 1'b0);
    send_point('0, -COORD_W'(2048), 1'b1);

    // a set of extremes to push the sums wide
    for (i = 1; i <= EXTREME_SET; i++) begin
      send_point($urandom_range(0, 7) != 0 ? -COORD_W'(2048) : COORD_W'(2047),
                 $urandom_range(0, 7) != 0 ? -COORD_W'(2048) : COORD_W'(2047),
                 i == EXTREME_SET);
    end

    sent = 0;
    sets = 0;
    while (sent < RAND_ITEMS) begin
      n = ($urandom_range(0, 99) < 15) ? 1 : $urandom_range(2, 20);
      sender_calm = ($urandom_range(0, 5) == 0);
      // receiver holds off while the sender keeps pushing sets in
      if (sets == 5) begin
        hold_req    = 1'b1;
        sender_calm = 1'b1;
      end
      send_set(n);
      sent += n;
      sets++;
    end
    sender_calm = 1'b0;
    point_ch.valid <= 1'b0;

    while (sb.waiting() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("conic_scatter_matrix_accumulator_top test passed");
    end else begin
      $display("conic_scatter_matrix_accumulator_top test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("conic_scatter_matrix_accumulator_top test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/csma_pkg.sv
rtl/core/csma_point_if.sv
rtl/core/csma_entry_if.sv
rtl/core/csma_ctrl.sv
rtl/core/csma_datapath.sv
rtl/core/conic_scatter_matrix_accumulator_top.sv
rtl/core/csma_checker.sv
test/tb_conic_scatter_matrix_accumulator_top.sv
